// File: rtl/vbp_pkg.sv
// Shared types and constants of the variable-length code bit packer.
package vbp_pkg;

    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int FILL_W    = 5;
    localparam int SYM_W     = 8;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [WORD_BITS-1:0] code;
        logic [LEN_W-1:0]     len;
    } t_entry;

endpackage

// File: rtl/vbp_code_table.sv
// Code table: one-write one-read synchronous memory with per-entry valid bits.
module vbp_code_table #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] i_wr_addr,
    input  vbp_pkg::t_entry                  i_wr_entry,
    input  logic                             i_rd_en,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] i_rd_addr,
    output vbp_pkg::t_entry                  o_rd_entry
);

    vbp_pkg::t_entry           r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0]  r_valid;
    vbp_pkg::t_entry           r_rd_data;
    logic                      r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits stand in for clearing the table: an entry never loaded
    // since reset reads as length zero, which encodes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_entry      = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_entry = '0;
        end
    end

endmodule

// File: rtl/vlc_bit_packer_unit.sv
// Top level of the variable-length code bit packer.
// The unit packs table-driven variable-length codes, least significant bit
// first, into 32-bit words. Every request carries a kind: a load writes one
// code table entry (code and length, lengths above 32 saturate to 32), an
// encode appends the code of its symbol masked to its length, and a flush
// returns the partial word, its bit count and the saturating total bit
// count of the stream, then starts a new stream while keeping the table.
// A full word is returned as soon as 32 bits are filled; a code ending
// exactly on a word boundary leaves an empty accumulator. Loads, zero-length
// symbols, symbols at or above ALPHABET_SIZE and kind 3 return nothing.
// The unit takes one request per cycle unless input ready is low. Inside,
// a request first reads the code table, then merges the code into the
// accumulator through a 64-bit shifter and loads the output register. The
// table write of a load lands at the edge the load is accepted, so an encode
// in the very next cycle already sees the new entry. Input ready drops only
// when the merge stage holds a request that produces a result while the
// output register holds a result not yet taken. The table needs no clearing
// pass after reset: per-entry valid bits make unloaded entries read as empty.
module vlc_bit_packer_unit #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic [31:0] i_entry_code,
    input  logic [5:0]  i_entry_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_packed_word,
    output logic [5:0]  o_bit_count,
    output logic [31:0] o_stream_bits,
    output logic        o_last
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int WB = vbp_pkg::WORD_BITS;

    // Input side.
    logic              in_accept;
    logic              in_range;
    vbp_pkg::t_kind    in_kind;
    vbp_pkg::t_entry   wr_entry;
    logic [AW-1:0]     sym_idx;

    // Merge stage.
    logic              r_s1_valid;
    vbp_pkg::t_kind    r_s1_kind;
    logic              r_s1_in_range;
    vbp_pkg::t_entry   rd_entry;
    logic              s1_adv;

    // Stream state.
    logic [WB-1:0]               r_acc;
    logic [vbp_pkg::FILL_W-1:0]  r_fill;
    logic [WB-1:0]               r_total;
    logic [WB-1:0]               n_acc;
    logic [vbp_pkg::FILL_W-1:0]  n_fill;
    logic [WB-1:0]               n_total;

    // Result of the merge stage.
    logic                        has_res;
    logic [WB-1:0]               res_word;
    logic [vbp_pkg::LEN_W-1:0]   res_count;
    logic                        res_last;

    // Datapath temporaries.
    logic [WB-1:0]               code_m;
    logic [2*WB-1:0]             merged;
    logic [vbp_pkg::LEN_W-1:0]   sum;
    logic [WB:0]                 tot_sum;
    logic [WB-1:0]               tot_sat;

    logic                        r_out_valid;
    logic [WB-1:0]               r_out_word;
    logic [vbp_pkg::LEN_W-1:0]   r_out_count;
    logic [WB-1:0]               r_out_total;
    logic                        r_out_last;

    assign in_kind   = vbp_pkg::t_kind'(i_kind);
    assign in_accept = i_in_valid && o_in_ready;
    assign in_range  = (32'(i_symbol) < 32'(ALPHABET_SIZE));
    assign sym_idx   = i_symbol[AW-1:0];

    always_comb begin
        wr_entry.code = i_entry_code;
        wr_entry.len  = i_entry_length;
        if (i_entry_length > vbp_pkg::LEN_MAX) begin
            wr_entry.len = vbp_pkg::LEN_MAX;
        end
    end

    vbp_code_table #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (in_accept && (in_kind == vbp_pkg::KIND_LOAD) && in_range),
        .i_wr_addr  (sym_idx),
        .i_wr_entry (wr_entry),
        .i_rd_en    (in_accept),
        .i_rd_addr  (sym_idx),
        .o_rd_entry (rd_entry)
    );

    // Merge stage: mask the code, shift it up to the fill level and decide
    // whether a word is complete. Bits above the fill level are always zero,
    // so an OR is enough to append.
    always_comb begin
        code_m = rd_entry.code;
        if (!rd_entry.len[5]) begin
            code_m = rd_entry.code & ((32'h1 << rd_entry.len[4:0]) - 32'h1);
        end
        merged  = {{WB{1'b0}}, r_acc} | ({{WB{1'b0}}, code_m} << r_fill);
        sum     = {1'b0, r_fill} + rd_entry.len;
        tot_sum = {1'b0, r_total} + (WB+1)'(rd_entry.len);
        tot_sat = tot_sum[WB] ? {WB{1'b1}} : tot_sum[WB-1:0];

        n_acc     = r_acc;
        n_fill    = r_fill;
        n_total   = r_total;
        has_res   = 1'b0;
        res_word  = r_acc;
        res_count = {1'b0, r_fill};
        res_last  = 1'b0;

        case (r_s1_kind)
            vbp_pkg::KIND_ENCODE: begin
                if (r_s1_in_range && (rd_entry.len != '0)) begin
                    n_total = tot_sat;
                    if (sum[5]) begin
                        has_res   = 1'b1;
                        res_word  = merged[WB-1:0];
                        res_count = vbp_pkg::LEN_MAX;
                        n_acc     = merged[2*WB-1:WB];
                    end else begin
                        n_acc = merged[WB-1:0];
                    end
                    n_fill = sum[4:0];
                end
            end
            vbp_pkg::KIND_FLUSH: begin
                has_res  = 1'b1;
                res_last = 1'b1;
                n_acc    = '0;
                n_fill   = '0;
                n_total  = '0;
            end
            default: begin
            end
        endcase
    end

    assign s1_adv     = r_s1_valid && (!has_res || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // A flush reports the total of the stream it closes; a full word reports
    // the running total including the code that filled it.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind     <= in_kind;
            r_s1_in_range <= in_range;
        end
        if (s1_adv && has_res) begin
            r_out_word  <= res_word;
            r_out_count <= res_count;
            r_out_total <= res_last ? r_total : n_total;
            r_out_last  <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_fill      <= '0;
            r_total     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && has_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_acc   <= n_acc;
                r_fill  <= n_fill;
                r_total <= n_total;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_word = r_out_word;
    assign o_bit_count   = r_out_count;
    assign o_stream_bits = r_out_total;
    assign o_last        = r_out_last;

    // Pending bits never reach at or above the fill level.
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_fill) == '0)
        else $error("accumulator holds bits above the fill level");

    // A full word carries 32 bits; a flush carries fewer.
    a_count_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_last && (o_bit_count < vbp_pkg::LEN_MAX)) ||
                         (!o_last && (o_bit_count == vbp_pkg::LEN_MAX))))
        else $error("bit count does not match result kind");

    // A flush leaves an empty stream behind.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_s1_kind == vbp_pkg::KIND_FLUSH)) |=>
            ((r_acc == '0) && (r_fill == '0) && (r_total == '0)))
        else $error("flush did not clear the stream state");

    // A stalled merge stage keeps its request.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_kind)))
        else $error("merge stage lost a stalled request");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the variable-length code bit packer with a random driver and monitor.
module testbench;

    localparam int ALPHABET = 256;
    // Kind 3 has no member in the package enum; the unit must ignore it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER = 120;
    localparam int RANDOM_ITEMS = 680;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  symbol;
        logic [31:0] code;
        logic [5:0]  length;
    } t_request;

    typedef struct {
        logic [31:0] word;
        logic [5:0]  count;
        logic [31:0] total;
        logic        last;
    } t_packed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = vbp_pkg::KIND_LOAD;
    logic [7:0]  i_symbol = 8'd0;
    logic [31:0] i_entry_code = 32'd0;
    logic [5:0]  i_entry_length = 6'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_packed_word;
    logic [5:0]  o_bit_count;
    logic [31:0] o_stream_bits;
    logic        o_last;

    vlc_bit_packer_unit #(
        .ALPHABET_SIZE(ALPHABET)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_symbol(i_symbol),
        .i_entry_code(i_entry_code),
        .i_entry_length(i_entry_length),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_packed_word(o_packed_word),
        .o_bit_count(o_bit_count),
        .o_stream_bits(o_stream_bits),
        .o_last(o_last)
    );

    // Requests waiting to be driven, and the words the unit still owes us.
    t_request request_queue[$];
    t_packed  expected_words[$];
    int       total_requests = 0;
    int       requests_done = 0;
    int       errors = 0;

    // Shadow copy of the packer state.
    logic [31:0] shadow_code [ALPHABET];
    logic [5:0]  shadow_len [ALPHABET];
    logic [31:0] shadow_acc;
    logic [4:0]  shadow_fill;
    logic [31:0] shadow_total;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_request(input logic [1:0] kind, input logic [7:0] symbol,
                                        input logic [31:0] code, input logic [5:0] length);
        t_request r;
        r.kind = kind;
        r.symbol = symbol;
        r.code = code;
        r.length = length;
        request_queue.push_back(r);
    endfunction

    // Applies one accepted request to the shadow state and queues the word it causes.
    function automatic void pack_request(input t_request r);
        logic [5:0]  len;
        logic [63:0] code;
        logic [63:0] merged;
        int          sum;
        t_packed     res;
        case (r.kind)
            vbp_pkg::KIND_LOAD: begin
                if (int'(r.symbol) < ALPHABET) begin
                    shadow_code[r.symbol] = r.code;
                    shadow_len[r.symbol] = (r.length > vbp_pkg::LEN_MAX) ? vbp_pkg::LEN_MAX
                                                                         : r.length;
                end
            end
            vbp_pkg::KIND_ENCODE: begin
                // Absent symbols and symbols outside the alphabet add nothing.
                if (int'(r.symbol) < ALPHABET && shadow_len[r.symbol] != 6'd0) begin
                    len = shadow_len[r.symbol];
                    code = {32'd0, shadow_code[r.symbol]} & ((64'd1 << len) - 64'd1);
                    merged = {32'd0, shadow_acc} | (code << shadow_fill);
                    if (shadow_total > 32'hFFFF_FFFF - {26'd0, len}) begin
                        shadow_total = 32'hFFFF_FFFF;
                    end else begin
                        shadow_total = shadow_total + {26'd0, len};
                    end
                    sum = int'(shadow_fill) + int'(len);
                    if (sum >= vbp_pkg::WORD_BITS) begin
                        res.word = merged[31:0];
                        res.count = vbp_pkg::LEN_MAX;
                        res.total = shadow_total;
                        res.last = 1'b0;
                        expected_words.push_back(res);
                        shadow_acc = merged[63:32];
                        shadow_fill = 5'(sum - vbp_pkg::WORD_BITS);
                    end else begin
                        shadow_acc = merged[31:0];
                        shadow_fill = 5'(sum);
                    end
                end
            end
            vbp_pkg::KIND_FLUSH: begin
                res.word = shadow_acc;
                res.count = {1'b0, shadow_fill};
                res.total = shadow_total;
                res.last = 1'b1;
                expected_words.push_back(res);
                shadow_acc = '0;
                shadow_fill = '0;
                shadow_total = '0;
            end
            default: ;
        endcase
    endfunction

    // Driver: one request at a time, with a random gap before each one.
    t_request in_flight;
    int       send_gap = 0;
    bit       send_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = $urandom_range(0, 10);
        end else begin
            if (i_in_valid && o_in_ready) begin
                pack_request(in_flight);
                requests_done++;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, 10);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    in_flight = request_queue.pop_front();
                    i_kind <= in_flight.kind;
                    i_symbol <= in_flight.symbol;
                    i_entry_code <= in_flight.code;
                    i_entry_length <= in_flight.length;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls per word, plus one long hold-off that backs the unit up.
    int recv_gap = 0;
    int hold_left = 0;
    int words_seen = 0;
    bit hold_done = 1'b0;
    bit recv_burst = 1'b0;

    always @(posedge i_clk) begin
        t_packed want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h count %0d total %h last %b", $time,
                             o_packed_word, o_bit_count, o_stream_bits, o_last);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_packed_word !== want.word) begin
                        $display("%0t: packed_word expected %h, got %h", $time,
                                 want.word, o_packed_word);
                        errors++;
                    end
                    if (o_bit_count !== want.count) begin
                        $display("%0t: bit_count expected %0d, got %0d", $time,
                                 want.count, o_bit_count);
                        errors++;
                    end
                    if (o_stream_bits !== want.total) begin
                        $display("%0t: stream_bits expected %h, got %h", $time,
                                 want.total, o_stream_bits);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %b, got %b", $time, want.last, o_last);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_gap = recv_burst ? 0 : $urandom_range(0, 10);
                if (!hold_done && words_seen == HOLD_AFTER) begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int          counted;
        int          pick;
        logic [7:0]  sym;
        logic [5:0]  len;
        for (int i = 0; i < ALPHABET; i++) begin
            shadow_code[i] = '0;
            shadow_len[i] = '0;
        end
        shadow_acc = '0;
        shadow_fill = '0;
        shadow_total = '0;

        // Directed part. The table starts empty, so the first two requests
        // check the empty flush and an encode of an absent symbol.
        add_request(vbp_pkg::KIND_FLUSH, 8'd0, 32'hFFFF_FFFF, 6'd63);
        add_request(vbp_pkg::KIND_ENCODE, 8'd7, 32'hFFFF_FFFF, 6'd32);
        add_request(KIND_UNUSED, 8'd0, 32'hFFFF_FFFF, 6'd63);
        // A full 32-bit code from an empty word lands exactly on the boundary.
        add_request(vbp_pkg::KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        add_request(vbp_pkg::KIND_ENCODE, 8'd0, 32'h0, 6'd0);
        // An over-long length saturates to 32 bits.
        add_request(vbp_pkg::KIND_LOAD, 8'd255, 32'hDEAD_BEEF, 6'd63);
        // Code bits above the length must be dropped.
        add_request(vbp_pkg::KIND_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd5);
        add_request(vbp_pkg::KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_ENCODE, 8'd255, 32'h0, 6'd0);
        // An encode right behind the load of its entry.
        add_request(vbp_pkg::KIND_LOAD, 8'd2, 32'hFFFF_FFF7, 6'd3);
        add_request(vbp_pkg::KIND_ENCODE, 8'd2, 32'h0, 6'd0);
        // 8 pending bits plus 24 fill the word exactly.
        add_request(vbp_pkg::KIND_LOAD, 8'd3, 32'h00FF_FFFF, 6'd24);
        add_request(vbp_pkg::KIND_ENCODE, 8'd3, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_FLUSH, 8'd255, 32'h0, 6'd0);
        // Loading a zero length marks the entry absent.
        add_request(vbp_pkg::KIND_LOAD, 8'd4, 32'h1234_5678, 6'd0);
        add_request(vbp_pkg::KIND_ENCODE, 8'd4, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_LOAD, 8'd5, 32'hAAAA_AAAB, 6'd1);
        add_request(vbp_pkg::KIND_ENCODE, 8'd5, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_LOAD, 8'd1, 32'h5555_5555, 6'd31);
        add_request(vbp_pkg::KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        add_request(vbp_pkg::KIND_FLUSH, 8'd128, 32'h0, 6'd0);
        // A flush right after a flush is empty again.
        add_request(vbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);

        // Random part: fill a small working set of symbols first, then mostly
        // encode from it, with loads, flushes and unused kinds mixed in.
        for (int i = 0; i < 16; i++) begin
            add_request(vbp_pkg::KIND_LOAD, 8'(i), $urandom, 6'($urandom_range(1, 32)));
        end
        counted = 16;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            sym = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(0, 255));
            if (pick < 72) begin
                add_request(vbp_pkg::KIND_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
                counted++;
            end else if (pick < 86) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    len = 6'd0;
                end else if (pick == 1) begin
                    len = 6'($urandom_range(33, 63));
                end else begin
                    len = 6'($urandom_range(1, 32));
                end
                add_request(vbp_pkg::KIND_LOAD, sym, $urandom, len);
                counted++;
            end else if (pick < 94) begin
                add_request(vbp_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                            6'($urandom_range(0, 63)));
                counted++;
            end else begin
                add_request(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                            6'($urandom_range(0, 63)));
            end
        end
        // Close the stream so the last pending bits come out.
        add_request(vbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
        total_requests = request_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_done < total_requests) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, expected_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
